// ===== sv/ivs_pkg.sv =====
// types, constants and phase tables for the inchworm valve sequencer
// used by ivs_step and inchworm_valve_sequencer; depends on nothing else
package ivs_pkg;

	localparam int unsigned TimeW = 32;

	typedef logic [TimeW-1:0] time_t;
	typedef logic [2:0]       phase_t;
	typedef logic [2:0]       valve_t;
	typedef logic [1:0]       cfg_idx_t;

	localparam cfg_idx_t CFG_TICK  = 2'd0;
	localparam cfg_idx_t CFG_CYCLE = 2'd1;
	localparam cfg_idx_t CFG_GRIP  = 2'd2;

	localparam phase_t PH_INIT     = 3'd0;
	localparam phase_t PH_OPEN_FG  = 3'd1;
	localparam phase_t PH_ELONG    = 3'd2;
	localparam phase_t PH_CLOSE_FG = 3'd3;
	localparam phase_t PH_OPEN_MG  = 3'd4;
	localparam phase_t PH_RETRACT  = 3'd5;
	localparam phase_t PH_CLOSE_MG = 3'd6;
	localparam phase_t PH_DEAD     = 3'd7;

	localparam valve_t VALVE_RESET = 3'd7;
	localparam valve_t VALVE_OFF   = 3'd0;

	typedef struct packed {
		logic   valid;
		logic   use_act;
		phase_t next;
		valve_t valves;
	} edge_t;

	// state after one tick, handed from the step logic to the registers
	typedef struct packed {
		phase_t phase;
		valve_t valves;
		time_t  elapsed;
	} step_t;

	function automatic edge_t mk_edge(logic use_act, phase_t next, valve_t valves);
		edge_t e;
		e.valid   = 1'b1;
		e.use_act = use_act;
		e.next    = next;
		e.valves  = valves;
		return e;
	endfunction

	function automatic edge_t edge_lookup(logic rev, phase_t ph);
		edge_t e;
		e = '{valid: 1'b0, use_act: 1'b0, next: PH_DEAD, valves: VALVE_OFF};
		if (!rev) begin
			case (ph)
				PH_INIT:     e = mk_edge(1'b0, PH_OPEN_FG,  3'd2);
				PH_OPEN_FG:  e = mk_edge(1'b0, PH_ELONG,    3'd6);
				PH_ELONG:    e = mk_edge(1'b1, PH_CLOSE_FG, 3'd7);
				PH_CLOSE_FG: e = mk_edge(1'b0, PH_OPEN_MG,  3'd5);
				PH_OPEN_MG:  e = mk_edge(1'b0, PH_RETRACT,  3'd1);
				PH_RETRACT:  e = mk_edge(1'b1, PH_CLOSE_MG, 3'd3);
				PH_CLOSE_MG: e = mk_edge(1'b0, PH_OPEN_FG,  3'd2);
				default:     ;
			endcase
		end else begin
			case (ph)
				PH_INIT:     e = mk_edge(1'b0, PH_RETRACT,  3'd1);
				PH_OPEN_FG:  e = mk_edge(1'b1, PH_CLOSE_MG, 3'd3);
				PH_ELONG:    e = mk_edge(1'b0, PH_OPEN_FG,  3'd1);
				PH_CLOSE_FG: e = mk_edge(1'b0, PH_ELONG,    3'd5);
				PH_OPEN_MG:  e = mk_edge(1'b1, PH_CLOSE_FG, 3'd7);
				PH_RETRACT:  e = mk_edge(1'b0, PH_OPEN_MG,  3'd6);
				PH_CLOSE_MG: e = mk_edge(1'b0, PH_RETRACT,  3'd2);
				default:     ;
			endcase
		end
		return e;
	endfunction

	// (cycle - 4*grip) / 2, clamped at zero
	function automatic time_t act_time(time_t cyc, time_t grip);
		logic [TimeW+1:0] four_g;
		logic [TimeW+1:0] cyc_w;
		logic [TimeW+1:0] diff;
		four_g = {grip, 2'b00};
		cyc_w  = {2'b00, cyc};
		diff   = cyc_w - four_g;
		if (cyc_w < four_g)
			return '0;
		return diff[TimeW:1];
	endfunction

endpackage

// ===== sv/ivs_step.sv =====
// next-state logic for one sampling tick: saturating count, wait compare, phase table
// depends on ivs_pkg
module ivs_step (
	input  logic [1:0]     move_dir,
	input  ivs_pkg::phase_t phase,
	input  ivs_pkg::valve_t valves,
	input  ivs_pkg::time_t  elapsed,
	input  ivs_pkg::time_t  tick_period,
	input  ivs_pkg::time_t  grip_period,
	input  ivs_pkg::time_t  act_period,
	output ivs_pkg::step_t  nxt
);

	logic [ivs_pkg::TimeW:0] sum;
	ivs_pkg::time_t          sat;
	ivs_pkg::time_t          wait_len;
	ivs_pkg::edge_t          e;

	always_comb begin
		sum      = {1'b0, elapsed} + {1'b0, tick_period};
		sat      = sum[ivs_pkg::TimeW] ? '1 : sum[ivs_pkg::TimeW-1:0];
		// sign bit picks the reverse cycle
		e        = ivs_pkg::edge_lookup(move_dir[1], phase);
		wait_len = e.use_act ? act_period : grip_period;

		nxt.phase   = phase;
		nxt.valves  = valves;
		nxt.elapsed = sat;
		if (move_dir == 2'b00) begin
			nxt.valves = ivs_pkg::VALVE_OFF;
		end else if (e.valid && (sat >= wait_len)) begin
			nxt.phase   = e.next;
			nxt.valves  = e.valves;
			nxt.elapsed = '0;
		end
	end

endmodule

// ===== sv/inchworm_valve_sequencer.sv =====
// top level of the inchworm valve sequencer: config registers, state and result registers
// depends on ivs_pkg and ivs_step
//
// Usage
//   cfg channel: cfg_valid/cfg_ready with cfg_index (0 tick, 1 cycle, 2 grip period)
//   and cfg_data; cfg_ready is always high, indexes beyond two are dropped. The
//   actuation time is worked out at the write and held in a register of its own.
//   in channel: one request per sampling tick carrying move_dir.
//   out channel: one result per request, valve_bits and phase_now after the tick.
// Timing and throughput
//   a result appears in the cycle after its request is taken; unless the output stalls,
//   a new request can be taken every cycle, set by one add-and-compare on the state registers.
// Reset
//   arst_n clears the periods, the counter and the phase, sets the valves to 7
//   and empties the output.
// Stall
//   while a result waits on out_ready the state holds and in_ready drops, so
//   nothing is lost; in_ready is high whenever the output is empty or being taken.
module inchworm_valve_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  ivs_pkg::cfg_idx_t    cfg_index,
	input  ivs_pkg::time_t       cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [1:0]    move_dir,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ivs_pkg::valve_t      valve_bits,
	output ivs_pkg::phase_t      phase_now
);

	ivs_pkg::time_t  tick_q, cycle_q, grip_q, act_q;
	ivs_pkg::time_t  elapsed_q;
	ivs_pkg::phase_t phase_q;
	ivs_pkg::valve_t valve_q;
	logic            out_valid_q;
	ivs_pkg::step_t  nxt;
	logic            in_acc;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			cycle_q <= '0;
			grip_q  <= '0;
			act_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ivs_pkg::CFG_TICK: tick_q <= cfg_data;
				ivs_pkg::CFG_CYCLE: begin
					cycle_q <= cfg_data;
					act_q   <= ivs_pkg::act_time(cfg_data, grip_q);
				end
				ivs_pkg::CFG_GRIP: begin
					grip_q <= cfg_data;
					act_q  <= ivs_pkg::act_time(cycle_q, cfg_data);
				end
				default: ;
			endcase
		end
	end

	ivs_step u_step (
		.move_dir    (move_dir),
		.phase       (phase_q),
		.valves      (valve_q),
		.elapsed     (elapsed_q),
		.tick_period (tick_q),
		.grip_period (grip_q),
		.act_period  (act_q),
		.nxt         (nxt)
	);

	// the state registers double as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ivs_pkg::PH_INIT;
			valve_q     <= ivs_pkg::VALVE_RESET;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q   <= nxt.phase;
				valve_q   <= nxt.valves;
				elapsed_q <= nxt.elapsed;
			end
			if (in_acc)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign valve_bits = valve_q;
	assign phase_now  = phase_q;

`ifndef SYNTHESIS
	a_no_dead_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != ivs_pkg::PH_DEAD)
		else $error("phase register reached the unused code");

	a_stop_valves_off: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && move_dir == 2'sb00) |=> (out_valid && valve_bits == ivs_pkg::VALVE_OFF
			&& phase_q == $past(phase_q)))
		else $error("stop request did not clear valves or moved the phase");

	a_phase_change_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && nxt.phase != phase_q) |=> (elapsed_q == '0))
		else $error("phase advanced without clearing the counter");

	a_act_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		act_q == ivs_pkg::act_time(cycle_q, grip_q))
		else $error("actuation time out of step with its registers");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(valve_bits) && $stable(phase_now)))
		else $error("result changed while stalled");
`endif

endmodule

// ===== tb/inchworm_valve_sequencer_tb.sv =====
// testbench for inchworm_valve_sequencer: directed and random sampling ticks, each result
// checked against a predictor of the phase, valve and elapsed-time state
// depends on ivs_pkg and the inchworm_valve_sequencer rtl
module inchworm_valve_sequencer_tb;

	typedef logic signed [1:0] dir_t;

	localparam dir_t              DIR_STOP    = 2'sb00;
	localparam dir_t              DIR_FWD     = 2'sb01;
	localparam dir_t              DIR_NEG2    = 2'sb10;
	localparam dir_t              DIR_REV     = 2'sb11;
	localparam ivs_pkg::cfg_idx_t CFG_SPARE   = 2'd3;
	localparam ivs_pkg::time_t    TIME_MAX    = '1;
	localparam int                CYCLE_LIMIT = 600000;
	localparam int                HOLD_CYCLES = 90;
	localparam int                GAP_MAX     = 17;

	typedef struct packed {
		logic            ok;
		logic            act;
		ivs_pkg::phase_t nx;
		ivs_pkg::valve_t vb;
	} hop_t;

	typedef struct packed {
		ivs_pkg::valve_t valves;
		ivs_pkg::phase_t phase;
	} tick_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	ivs_pkg::cfg_idx_t cfg_index = ivs_pkg::CFG_TICK;
	ivs_pkg::time_t    cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	dir_t              move_dir  = DIR_STOP;
	logic              out_valid;
	logic              out_ready = 1'b0;
	ivs_pkg::valve_t   valve_bits;
	ivs_pkg::phase_t   phase_now;

	// predicted state and register copies
	ivs_pkg::phase_t cur_phase  = ivs_pkg::PH_INIT;
	ivs_pkg::valve_t cur_valves = ivs_pkg::VALVE_RESET;
	ivs_pkg::time_t  elapsed    = '0;
	ivs_pkg::time_t  tick_reg   = '0;
	ivs_pkg::time_t  cycle_reg  = '0;
	ivs_pkg::time_t  grip_reg   = '0;

	tick_result_t pending_results[$];
	int           mismatch_count = 0;
	int           ticks_sent     = 0;
	int           cycle_count    = 0;
	logic         quiet          = 1'b0;
	logic         hold_request   = 1'b0;

	inchworm_valve_sequencer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.move_dir   (move_dir),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.valve_bits (valve_bits),
		.phase_now  (phase_now)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic int draw_gap();
		if (quiet)
			return 0;
		return int'($urandom_range(0, GAP_MAX));
	endfunction

	// wait kind, next phase and valve pattern for one step of either cycle
	function automatic hop_t next_hop(logic rev, ivs_pkg::phase_t ph);
		hop_t h;
		h = {1'b0, 1'b0, ivs_pkg::PH_DEAD, ivs_pkg::VALVE_OFF};
		case ({rev, ph})
			{1'b0, ivs_pkg::PH_INIT}:     h = {1'b1, 1'b0, ivs_pkg::PH_OPEN_FG, 3'd2};
			{1'b0, ivs_pkg::PH_OPEN_FG}:  h = {1'b1, 1'b0, ivs_pkg::PH_ELONG, 3'd6};
			{1'b0, ivs_pkg::PH_ELONG}:    h = {1'b1, 1'b1, ivs_pkg::PH_CLOSE_FG, 3'd7};
			{1'b0, ivs_pkg::PH_CLOSE_FG}: h = {1'b1, 1'b0, ivs_pkg::PH_OPEN_MG, 3'd5};
			{1'b0, ivs_pkg::PH_OPEN_MG}:  h = {1'b1, 1'b0, ivs_pkg::PH_RETRACT, 3'd1};
			{1'b0, ivs_pkg::PH_RETRACT}:  h = {1'b1, 1'b1, ivs_pkg::PH_CLOSE_MG, 3'd3};
			{1'b0, ivs_pkg::PH_CLOSE_MG}: h = {1'b1, 1'b0, ivs_pkg::PH_OPEN_FG, 3'd2};
			{1'b1, ivs_pkg::PH_INIT}:     h = {1'b1, 1'b0, ivs_pkg::PH_RETRACT, 3'd1};
			{1'b1, ivs_pkg::PH_OPEN_FG}:  h = {1'b1, 1'b1, ivs_pkg::PH_CLOSE_MG, 3'd3};
			{1'b1, ivs_pkg::PH_ELONG}:    h = {1'b1, 1'b0, ivs_pkg::PH_OPEN_FG, 3'd1};
			{1'b1, ivs_pkg::PH_CLOSE_FG}: h = {1'b1, 1'b0, ivs_pkg::PH_ELONG, 3'd5};
			{1'b1, ivs_pkg::PH_OPEN_MG}:  h = {1'b1, 1'b1, ivs_pkg::PH_CLOSE_FG, 3'd7};
			{1'b1, ivs_pkg::PH_RETRACT}:  h = {1'b1, 1'b0, ivs_pkg::PH_OPEN_MG, 3'd6};
			{1'b1, ivs_pkg::PH_CLOSE_MG}: h = {1'b1, 1'b0, ivs_pkg::PH_RETRACT, 3'd2};
			default:                      ;
		endcase
		return h;
	endfunction

	// half of what the cycle leaves after four gripper phases, never below zero
	function automatic ivs_pkg::time_t stroke_time();
		logic [33:0] cyc;
		logic [33:0] four_grip;
		cyc       = {2'b00, cycle_reg};
		four_grip = {2'b00, grip_reg} << 2;
		if (cyc < four_grip)
			return '0;
		return ivs_pkg::time_t'((cyc - four_grip) >> 1);
	endfunction

	task automatic advance_sequencer(input dir_t dir);
		logic [32:0]    sum;
		hop_t           h;
		ivs_pkg::time_t hold_for;
		tick_result_t   res;
		sum     = {1'b0, elapsed} + {1'b0, tick_reg};
		elapsed = sum[32] ? TIME_MAX : sum[31:0];
		if (dir == DIR_STOP) begin
			cur_valves = ivs_pkg::VALVE_OFF;
		end else begin
			// top bit set means any negative direction, so reverse
			h = next_hop(dir[1], cur_phase);
			if (h.ok) begin
				hold_for = h.act ? stroke_time() : grip_reg;
				if (elapsed >= hold_for) begin
					cur_phase  = h.nx;
					cur_valves = h.vb;
					elapsed    = '0;
				end
			end
		end
		res.valves = cur_valves;
		res.phase  = cur_phase;
		pending_results.push_back(res);
	endtask

	task automatic send_tick(input dir_t dir);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		move_dir <= dir;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_sequencer(dir);
		ticks_sent++;
	endtask

	task automatic write_reg(input ivs_pkg::cfg_idx_t idx, input ivs_pkg::time_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			ivs_pkg::CFG_TICK:  tick_reg  = val;
			ivs_pkg::CFG_CYCLE: cycle_reg = val;
			ivs_pkg::CFG_GRIP:  grip_reg  = val;
			default:            ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input ivs_pkg::time_t tick, input ivs_pkg::time_t cyc,
			input ivs_pkg::time_t grip);
		write_reg(ivs_pkg::CFG_TICK, tick);
		write_reg(ivs_pkg::CFG_CYCLE, cyc);
		write_reg(ivs_pkg::CFG_GRIP, grip);
	endtask

	// every request gives a result, so an empty queue means the block is idle
	task automatic settle_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// reset values: every wait is zero, so each moving tick advances the phase
	task automatic test_zero_config();
		send_tick(DIR_STOP);
		repeat (7) send_tick(DIR_FWD);
		repeat (3) send_tick(DIR_REV);
		send_tick(DIR_NEG2);
		send_tick(DIR_STOP);
	endtask

	task automatic test_extreme_config();
		settle_results();
		// counter reaches its top value and the actuation time clamps to zero
		apply_setting(TIME_MAX, TIME_MAX, TIME_MAX);
		repeat (2) send_tick(DIR_FWD);
		repeat (2) send_tick(DIR_REV);
		settle_results();
		// four gripper times overflow 32 bits, stopped ticks keep counting
		apply_setting(32'h8000_0000, TIME_MAX, 32'h4000_0001);
		repeat (3) send_tick(DIR_STOP);
		repeat (2) send_tick(DIR_FWD);
		send_tick(DIR_NEG2);
		settle_results();
		// counter frozen, actuation phases never finish; spare index must be dropped
		apply_setting('0, 32'd10, '0);
		write_reg(CFG_SPARE, TIME_MAX);
		repeat (4) send_tick(DIR_FWD);
		send_tick(DIR_REV);
	endtask

	task automatic pick_setting();
		int unsigned mode;
		mode = $urandom_range(0, 6);
		case (mode)
			0, 1, 2: apply_setting($urandom_range(1, 4), $urandom_range(0, 100),
					$urandom_range(0, 12));
			3:       apply_setting('0, $urandom_range(0, 6), $urandom_range(0, 1));
			4:       apply_setting($urandom, $urandom, $urandom);
			5:       apply_setting($urandom_range(1, 8), $urandom_range(0, 40),
					$urandom_range(8, 20));
			default: apply_setting(TIME_MAX, $urandom_range(0, 1) ? TIME_MAX : '0,
					$urandom_range(0, 1) ? TIME_MAX : '0);
		endcase
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_SPARE, $urandom);
	endtask

	task automatic test_random_walk();
		int          target;
		int unsigned len;
		logic [1:0]  bits;
		dir_t        dir;
		for (int p = 0; p < 10; p++) begin
			settle_results();
			pick_setting();
			quiet  = ($urandom_range(0, 3) == 0);
			target = ticks_sent + 110;
			while (ticks_sent < target) begin
				if ($urandom_range(0, 99) < 85) begin
					// a run of ticks that all go the same way, forward or reverse
					dir = $urandom_range(0, 1) ? DIR_FWD : DIR_REV;
					len = $urandom_range(1, 30);
					repeat (len) send_tick(dir);
				end else begin
					len = $urandom_range(1, 4);
					repeat (len) begin
						bits = 2'($urandom_range(0, 3));
						send_tick(bits);
					end
				end
			end
		end
		quiet = 1'b0;
	endtask

	// sink holds off for a long while so the output fills and the input stalls
	task automatic test_backpressure();
		settle_results();
		apply_setting(32'd1, 32'd30, 32'd2);
		quiet        = 1'b1;
		hold_request = 1'b1;
		repeat (40) send_tick($urandom_range(0, 1) ? DIR_FWD : DIR_REV);
		quiet = 1'b0;
	endtask

	initial begin : result_sink
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_request = 1'b0;
			end
			gap = draw_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result valves %0d phase %0d",
					valve_bits, phase_now));
			end else begin
				want = pending_results.pop_front();
				if (valve_bits !== want.valves)
					report_mismatch($sformatf("valve_bits got %0d want %0d",
						valve_bits, want.valves));
				if (phase_now !== want.phase)
					report_mismatch($sformatf("phase_now got %0d want %0d",
						phase_now, want.phase));
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_config();
		test_extreme_config();
		test_random_walk();
		test_backpressure();
		settle_results();
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== inchworm_valve_sequencer.f =====
sv/ivs_pkg.sv
sv/ivs_step.sv
sv/inchworm_valve_sequencer.sv
tb/inchworm_valve_sequencer_tb.sv
